// File: hw/rtl/tsb_pkg.sv
// ----------------------------------------------------------------------------
// tsb_pkg
// shared constants, codes and types of the texture slot batcher
// ----------------------------------------------------------------------------
package tsb_pkg;

   // default sizing
   localparam int SLOT_COUNT_DEFAULT      = 32;
   localparam int TEXTURE_ID_BITS_DEFAULT = 16;

   // result field widths
   localparam int SLOT_W        = 5;
   localparam int CAUSE_W       = 2;
   localparam int QUAD_W        = 14;
   localparam int BATCH_SLOTS_W = 6;
   localparam int STAT_W        = 32;
   localparam int RSP_FIELDS_W  = SLOT_W + QUAD_W + BATCH_SLOTS_W + 2 * STAT_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   // request type codes
   localparam int REQ_TYPE_W = 2;
   localparam logic [REQ_TYPE_W-1:0] REQ_QUAD  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_END   = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd2;

   // flush cause codes
   localparam logic [CAUSE_W-1:0] CAUSE_NONE  = 2'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_SLOTS = 2'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_QUADS = 2'd2;
   localparam logic [CAUSE_W-1:0] CAUSE_END   = 2'd3;

   // configuration registers
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 14;
   localparam int SLOT_LIMIT_W = 6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUAD_LIMIT = 1'd1;
   localparam logic [SLOT_LIMIT_W-1:0] SLOT_LIMIT_RESET = 6'd32;
   localparam logic [QUAD_W-1:0]       QUAD_LIMIT_RESET = 14'd10000;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;    // take the item and register the slot matches
      logic update;     // resolve the item, update batch state, load result
      logic csr_write;  // write a configuration register
   } tsb_cmd_type;

endpackage

// File: hw/rtl/texture_slot_batcher.sv
// ----------------------------------------------------------------------------
// texture_slot_batcher
// binds quad textures to batch slots and reports batch flushes and statistics
// ----------------------------------------------------------------------------
// request channel (req_): req_tuser carries the request type (draw quad, end
// scene, clear statistics), req_tdata the texture id. every request item
// gives exactly one result item on the rsp_ channel, in order.
// result: rsp_tuser holds the flush cause; rsp_tdata the slot, the flushed
// batch's quad and slot counts and both wrapping statistics.
// configuration (csr_): index 0 slot limit, index 1 quad limit; write only
// while no item is in flight.
// timing: the slot tag compare runs in the accept cycle and its match vector
// is registered; the update step then resolves the slot, updates the batch
// state and loads the result register, waiting while a result is still held.
// rsp_tvalid rises with the loaded result; a new item is taken only once the
// last one has passed its update step, as compare and update run in series
// on the shared slot tags.
// stall: a held result stays in the output register while the next item is
// accepted and compared; that item then waits in its update step.
// reset: batch empty, statistics zero, limits 32 and 10000; slot tags are
// not cleared, entries past the used count are never consulted.
// ----------------------------------------------------------------------------
module texture_slot_batcher
   import tsb_pkg::*;
#(
   parameter  int SLOT_COUNT      = SLOT_COUNT_DEFAULT,
   parameter  int TEXTURE_ID_BITS = TEXTURE_ID_BITS_DEFAULT,
   localparam int REQ_DATA_W      = ((TEXTURE_ID_BITS + 7) / 8) * 8
)
(
   input  logic                   clock,
   input  logic                   reset,
   // request item
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TYPE_W-1:0]  req_tuser,   // [1:0] req_type
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // texture_id, zero filled
   // result item
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [CAUSE_W-1:0]     rsp_tuser,   // [1:0] flush_cause
   // [4:0] slot, [18:5] batch_quads, [24:19] batch_slots,
   // [56:25] draw_calls, [88:57] quads_total, rest zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   tsb_cmd_type cmd;

   // sequencing and handshakes
   tsb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .cmd        (cmd)
   );

   // slot tags, counters and result register
   tsb_dp #(
      .SLOT_COUNT      (SLOT_COUNT),
      .TEXTURE_ID_BITS (TEXTURE_ID_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// File: hw/rtl/tsb_ctrl.sv
// ----------------------------------------------------------------------------
// tsb_ctrl
// handshake and sequencing controller of the texture slot batcher
// ----------------------------------------------------------------------------
module tsb_ctrl
   import tsb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   output tsb_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      cmd.capture   = 1'b0;
      cmd.update    = 1'b0;
      cmd.csr_write = csr_valid && (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // wait here while the previous result is still held
            if (out_free) begin
               cmd.update   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/tsb_dp.sv
// ----------------------------------------------------------------------------
// tsb_dp
// slot tags, batch counters, statistics and result register
// ----------------------------------------------------------------------------
module tsb_dp
   import tsb_pkg::*;
#(
   parameter  int SLOT_COUNT      = SLOT_COUNT_DEFAULT,
   parameter  int TEXTURE_ID_BITS = TEXTURE_ID_BITS_DEFAULT,
   localparam int REQ_DATA_W      = ((TEXTURE_ID_BITS + 7) / 8) * 8
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  tsb_cmd_type            cmd,
   input  logic [REQ_TYPE_W-1:0]  req_tuser,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic [CAUSE_W-1:0]     rsp_tuser,
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int USED_W = $clog2(SLOT_COUNT + 1);
   localparam int LIM_W  = 7;
   localparam int PAD_W  = RSP_DATA_W - RSP_FIELDS_W;

   // slot tags, valid only below slots_used
   logic [TEXTURE_ID_BITS-1:0] slot_texture_ff [SLOT_COUNT];

   logic [USED_W-1:0]       slots_used_ff, slots_used_in;
   logic [QUAD_W-1:0]       batch_quads_ff, batch_quads_in;
   logic [STAT_W-1:0]       draw_calls_ff, draw_calls_in;
   logic [STAT_W-1:0]       quads_total_ff, quads_total_in;
   logic [SLOT_LIMIT_W-1:0] slot_limit_ff;
   logic [QUAD_W-1:0]       quad_limit_ff;

   // captured item
   logic [REQ_TYPE_W-1:0]      req_type_ff;
   logic [TEXTURE_ID_BITS-1:0] texture_ff;
   logic [SLOT_COUNT-1:0]      match_ff, match_in;

   // result register
   logic [CAUSE_W-1:0]    rsp_tuser_ff, cause;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_data_in;

   logic [IDX_W-1:0]         hit_idx, slot_sel;
   logic                     hit, full, wr_en;
   logic [LIM_W-1:0]         eff_slot_limit;
   logic [QUAD_W-1:0]        eff_quad_limit;
   logic [QUAD_W-1:0]        flushed_quads;
   logic [BATCH_SLOTS_W-1:0] flushed_slots;
   logic [1:0]               flush_count;

   // parallel tag compare on the incoming id
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         match_in[i] = (slot_texture_ff[i] == req_tdata[TEXTURE_ID_BITS-1:0])
                       && (USED_W'(i) < slots_used_ff);
      end
   end

   // lowest matching slot
   always_comb begin
      hit_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign hit = |match_ff;

   always_comb begin
      eff_slot_limit = LIM_W'(slot_limit_ff);
      if (eff_slot_limit == '0) begin
         eff_slot_limit = LIM_W'(1);
      end else if (eff_slot_limit > LIM_W'(SLOT_COUNT)) begin
         eff_slot_limit = LIM_W'(SLOT_COUNT);
      end
   end

   assign eff_quad_limit = (quad_limit_ff == '0) ? QUAD_W'(1) : quad_limit_ff;
   assign full           = LIM_W'(slots_used_ff) >= eff_slot_limit;

   always_comb begin
      slots_used_in  = slots_used_ff;
      batch_quads_in = batch_quads_ff;
      draw_calls_in  = draw_calls_ff;
      quads_total_in = quads_total_ff;
      cause          = CAUSE_NONE;
      flushed_quads  = '0;
      flushed_slots  = '0;
      flush_count    = 2'd0;
      slot_sel       = '0;
      wr_en          = 1'b0;
      unique case (req_type_ff)
         REQ_QUAD: begin
            if (hit) begin
               slot_sel = hit_idx;
            end else begin
               if (full) begin
                  // no free slot: close the batch before binding
                  cause          = CAUSE_SLOTS;
                  flushed_quads  = batch_quads_in;
                  flushed_slots  = BATCH_SLOTS_W'(slots_used_in);
                  flush_count    = 2'd1;
                  slots_used_in  = '0;
                  batch_quads_in = '0;
               end
               slot_sel      = slots_used_in[IDX_W-1:0];
               wr_en         = 1'b1;
               slots_used_in = USED_W'(slots_used_in + 1'b1);
            end
            batch_quads_in = batch_quads_in + 1'b1;
            quads_total_in = quads_total_ff + 1'b1;
            if (batch_quads_in >= eff_quad_limit) begin
               cause          = CAUSE_QUADS;
               flushed_quads  = batch_quads_in;
               flushed_slots  = BATCH_SLOTS_W'(slots_used_in);
               flush_count    = flush_count + 2'd1;
               slots_used_in  = '0;
               batch_quads_in = '0;
            end
            draw_calls_in = draw_calls_ff + STAT_W'(flush_count);
         end
         REQ_END: begin
            cause          = CAUSE_END;
            flushed_quads  = batch_quads_ff;
            flushed_slots  = BATCH_SLOTS_W'(slots_used_ff);
            slots_used_in  = '0;
            batch_quads_in = '0;
            draw_calls_in  = draw_calls_ff + 1'b1;
         end
         REQ_CLEAR: begin
            draw_calls_in  = '0;
            quads_total_in = '0;
         end
         default: begin
         end
      endcase
      rsp_data_in = {PAD_W'(0), quads_total_in, draw_calls_in, flushed_slots,
                     flushed_quads, SLOT_W'(slot_sel)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_used_ff  <= '0;
         batch_quads_ff <= '0;
         draw_calls_ff  <= '0;
         quads_total_ff <= '0;
         slot_limit_ff  <= SLOT_LIMIT_RESET;
         quad_limit_ff  <= QUAD_LIMIT_RESET;
      end else begin
         if (cmd.update) begin
            slots_used_ff  <= slots_used_in;
            batch_quads_ff <= batch_quads_in;
            draw_calls_ff  <= draw_calls_in;
            quads_total_ff <= quads_total_in;
         end
         if (cmd.csr_write) begin
            unique case (csr_index)
               CSR_SLOT_LIMIT: slot_limit_ff <= csr_data[SLOT_LIMIT_W-1:0];
               CSR_QUAD_LIMIT: quad_limit_ff <= csr_data[QUAD_W-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_tuser;
         texture_ff  <= req_tdata[TEXTURE_ID_BITS-1:0];
         match_ff    <= match_in;
      end
      if (cmd.update) begin
         rsp_tuser_ff <= cause;
         rsp_tdata_ff <= rsp_data_in;
         if (wr_en) begin
            slot_texture_ff[slot_sel] <= texture_ff;
         end
      end
   end

   assign rsp_tuser = rsp_tuser_ff;
   assign rsp_tdata = rsp_tdata_ff;

endmodule

// File: hw/rtl/tsb_checker.sv
// ----------------------------------------------------------------------------
// tsb_checker
// port level checks of the texture slot batcher, bound to the top level
// ----------------------------------------------------------------------------
module tsb_checker
   import tsb_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [CAUSE_W-1:0]    rsp_tuser,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result keeps its valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one item at a time: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted during update");

   // no flush means no flushed batch counts
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == CAUSE_NONE) |-> rsp_tdata[24:5] == '0)
      else $error("batch counts without flush");

endmodule

bind texture_slot_batcher tsb_checker u_tsb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
